// File: sv/dual_wheel_incremental_pi_drive_macros.svh
// Assertion macros used by the top level of the dual-wheel PI drive RTL.
`ifndef DUAL_WHEEL_INCREMENTAL_PI_DRIVE_MACROS_SVH
`define DUAL_WHEEL_INCREMENTAL_PI_DRIVE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DWPI_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DWPI_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/dwpi_pkg.sv
// Shared types, constants and width helpers of the dual-wheel PI drive.
package dwpi_pkg;

   localparam int SPEED_BITS_DEF     = 9;
   localparam int GAIN_FRAC_BITS_DEF = 12;

   localparam int OP_W       = 3;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 15;
   localparam int OFFSET_W   = 6;
   localparam int SCALE_W    = 8;
   localparam int ACC_W      = 16;
   localparam int DUTY_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [GAIN_W-1:0]   GAIN_PROP_RST    = 16'd4096;
   localparam logic [GAIN_W-1:0]   GAIN_DIFF_RST    = 16'd1638;
   localparam logic [LIMIT_W-1:0]  DRIVE_LIMIT_RST  = 15'd7000;
   localparam logic [OFFSET_W-1:0] SHARP_OFFSET_RST = 6'd5;
   localparam logic [SCALE_W-1:0]  DIRECT_SCALE_RST = 8'd100;

   typedef enum logic [OP_W-1:0] {
      OP_STOP,
      OP_FORWARD,
      OP_LEFT,
      OP_RIGHT,
      OP_SHARP_LEFT,
      OP_SHARP_RIGHT,
      OP_FIND,
      OP_ADJUST
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_PROP,
      REG_GAIN_DIFF,
      REG_DRIVE_LIMIT,
      REG_SHARP_OFFSET,
      REG_DIRECT_SCALE
   } reg_index_type;

   typedef enum logic [1:0] {
      LANE_ZERO,
      LANE_PI,
      LANE_DIRECT
   } lane_mode_type;

   typedef struct packed {
      logic load1;
      logic load2;
   } lane_ctl_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_prop;
      logic [GAIN_W-1:0]  gain_diff;
      logic [LIMIT_W-1:0] drive_limit;
      logic [SCALE_W-1:0] direct_scale;
   } lane_cfg_type;

   // A wheel target holds the speed plus the sharp-turn offset.
   function automatic int target_width(int speed_bits);
      return ((speed_bits > OFFSET_W + 1) ? speed_bits : OFFSET_W + 1) + 1;
   endfunction

   // A drive value holds either a clamped accumulator or a direct product.
   function automatic int drive_width(int speed_bits);
      return (speed_bits + SCALE_W + 1 > ACC_W) ? speed_bits + SCALE_W + 1 : ACC_W;
   endfunction

endpackage

// File: sv/dwpi_ifs.sv
// Request, response and register-write channel interfaces of the PI drive.
interface dwpi_req_if #(
   parameter int SPEED_BITS = dwpi_pkg::SPEED_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic [dwpi_pkg::OP_W-1:0]    op;
   logic signed [SPEED_BITS-1:0] target_speed;
   logic signed [SPEED_BITS-1:0] target_speed_right;
   logic signed [SPEED_BITS-1:0] measured_left;
   logic signed [SPEED_BITS-1:0] measured_right;

   modport source (output valid, op, target_speed, target_speed_right,
                   measured_left, measured_right, input ready);
   modport sink   (input valid, op, target_speed, target_speed_right,
                   measured_left, measured_right, output ready);
endinterface

interface dwpi_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          left_forward;
   logic [dwpi_pkg::DUTY_W-1:0]   left_duty;
   logic                          right_forward;
   logic [dwpi_pkg::DUTY_W-1:0]   right_duty;

   modport source (output valid, left_forward, left_duty, right_forward, right_duty,
                   input ready);
   modport sink   (input valid, left_forward, left_duty, right_forward, right_duty,
                   output ready);
endinterface

interface dwpi_csr_if;
   logic                              valid;
   logic                              ready;
   logic [dwpi_pkg::CSR_IDX_W-1:0]    index;
   logic [dwpi_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/dwpi_lane.sv
// One wheel lane: error, gain and direct products, then accumulator update, clamp and mode select.
module dwpi_lane #(
   parameter int SPEED_BITS     = dwpi_pkg::SPEED_BITS_DEF,
   parameter int GAIN_FRAC_BITS = dwpi_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  dwpi_pkg::lane_ctl_type                              ctl,
   input  dwpi_pkg::lane_cfg_type                              cfg,
   input  dwpi_pkg::lane_mode_type                             mode,
   input  logic signed [dwpi_pkg::target_width(SPEED_BITS)-1:0] target,
   input  logic signed [SPEED_BITS-1:0]                        measured,
   input  logic signed [SPEED_BITS-1:0]                        direct_speed,
   output logic signed [dwpi_pkg::drive_width(SPEED_BITS)-1:0] drive
);

   localparam int TW   = dwpi_pkg::target_width(SPEED_BITS);
   localparam int EW   = TW + 1;
   localparam int DEW  = EW + 1;
   localparam int PDW  = dwpi_pkg::GAIN_W + 1 + DEW;
   localparam int PPW  = dwpi_pkg::GAIN_W + 1 + EW;
   localparam int DW   = dwpi_pkg::drive_width(SPEED_BITS);
   localparam int AW   = dwpi_pkg::ACC_W;
   localparam int SW   = ((AW + GAIN_FRAC_BITS > PDW) ? AW + GAIN_FRAC_BITS : PDW) + 2;
   localparam int QW   = SW - GAIN_FRAC_BITS;

   logic signed [EW-1:0]  err;
   logic signed [DEW-1:0] err_delta;
   logic signed [PDW-1:0] prod_diff;
   logic signed [PPW-1:0] prod_prop;
   logic signed [DW-1:0]  prod_direct;

   logic signed [EW-1:0]  last_err_ff;
   logic signed [PDW-1:0] prod_diff_ff;
   logic signed [PPW-1:0] prod_prop_ff;
   logic signed [DW-1:0]  prod_direct_ff;
   dwpi_pkg::lane_mode_type mode_ff;

   logic signed [SW-1:0]  sum;
   logic signed [QW-1:0]  quot;
   logic signed [QW-1:0]  quot_trunc;
   logic signed [QW-1:0]  lim_pos;
   logic signed [QW-1:0]  lim_neg;
   logic                  round_up;
   logic signed [AW-1:0]  acc_in;
   logic signed [AW-1:0]  acc_ff;
   logic signed [DW-1:0]  drive_in;
   logic signed [DW-1:0]  drive_ff;

   always_comb begin
      err         = EW'(target) - EW'(measured);
      err_delta   = DEW'(err) - DEW'(last_err_ff);
      prod_diff   = PDW'($signed({1'b0, cfg.gain_diff})) * PDW'(err_delta);
      prod_prop   = PPW'($signed({1'b0, cfg.gain_prop})) * PPW'(err);
      prod_direct = DW'($signed({1'b0, cfg.direct_scale})) * DW'(direct_speed);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
      end else if (ctl.load1 && mode == dwpi_pkg::LANE_PI) begin
         last_err_ff <= err;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         prod_diff_ff   <= prod_diff;
         prod_prop_ff   <= prod_prop;
         prod_direct_ff <= prod_direct;
         mode_ff        <= mode;
      end
   end

   always_comb begin
      sum        = (SW'(acc_ff) <<< GAIN_FRAC_BITS) + SW'(prod_diff_ff) + SW'(prod_prop_ff);
      round_up   = sum[SW-1] && (|sum[GAIN_FRAC_BITS-1:0]);
      quot       = sum[SW-1:GAIN_FRAC_BITS];
      quot_trunc = quot + $signed({{(QW-1){1'b0}}, round_up});
      lim_pos    = $signed({{(QW-dwpi_pkg::LIMIT_W){1'b0}}, cfg.drive_limit});
      lim_neg    = -lim_pos;
      if (quot_trunc > lim_pos) begin
         acc_in = AW'(lim_pos);
      end else if (quot_trunc < lim_neg) begin
         acc_in = AW'(lim_neg);
      end else begin
         acc_in = AW'(quot_trunc);
      end
      case (mode_ff)
         dwpi_pkg::LANE_PI:     drive_in = DW'(acc_in);
         dwpi_pkg::LANE_DIRECT: drive_in = prod_direct_ff;
         default:               drive_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.load2 && mode_ff == dwpi_pkg::LANE_PI) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         drive_ff <= drive_in;
      end
   end

   assign drive = drive_ff;

endmodule

// File: sv/dwpi_merge.sv
// Output stage that turns both lane drive values into direction and duty.
module dwpi_merge #(
   parameter int SPEED_BITS = dwpi_pkg::SPEED_BITS_DEF
) (
   input  logic                                                clock,
   input  logic                                                load,
   input  logic signed [dwpi_pkg::drive_width(SPEED_BITS)-1:0] drive_left,
   input  logic signed [dwpi_pkg::drive_width(SPEED_BITS)-1:0] drive_right,
   output logic                                                left_forward,
   output logic [dwpi_pkg::DUTY_W-1:0]                         left_duty,
   output logic                                                right_forward,
   output logic [dwpi_pkg::DUTY_W-1:0]                         right_duty
);

   localparam int DW = dwpi_pkg::drive_width(SPEED_BITS);

   logic signed [DW-1:0]           neg_left;
   logic signed [DW-1:0]           neg_right;
   logic                           left_forward_in;
   logic                           right_forward_in;
   logic [dwpi_pkg::DUTY_W-1:0]    left_duty_in;
   logic [dwpi_pkg::DUTY_W-1:0]    right_duty_in;
   logic                           left_forward_ff;
   logic                           right_forward_ff;
   logic [dwpi_pkg::DUTY_W-1:0]    left_duty_ff;
   logic [dwpi_pkg::DUTY_W-1:0]    right_duty_ff;

   always_comb begin
      neg_left         = -drive_left;
      neg_right        = -drive_right;
      left_forward_in  = !drive_left[DW-1] && (|drive_left);
      right_forward_in = !drive_right[DW-1] && (|drive_right);
      left_duty_in     = drive_left[DW-1] ? neg_left[dwpi_pkg::DUTY_W-1:0]
                                          : drive_left[dwpi_pkg::DUTY_W-1:0];
      right_duty_in    = drive_right[DW-1] ? neg_right[dwpi_pkg::DUTY_W-1:0]
                                           : drive_right[dwpi_pkg::DUTY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         left_forward_ff  <= left_forward_in;
         left_duty_ff     <= left_duty_in;
         right_forward_ff <= right_forward_in;
         right_duty_ff    <= right_duty_in;
      end
   end

   assign left_forward  = left_forward_ff;
   assign left_duty     = left_duty_ff;
   assign right_forward = right_forward_ff;
   assign right_duty    = right_duty_ff;

endmodule

// File: sv/dual_wheel_incremental_pi_drive.sv
// Top level of the dual-wheel incremental PI drive.
// The block accepts one request per clock cycle unless stalled, and its response
// passes two stages in each wheel lane (gain products, then accumulator
// update with truncation and clamping) and one output register that forms the
// direction bits and duty magnitudes. The accumulator recurrence closes inside
// the second lane stage, so consecutive requests never wait on each other;
// only a held response that the sink does not take stalls the pipeline.
// Register writes are taken in any cycle and should be made while idle.
`include "dual_wheel_incremental_pi_drive_macros.svh"

module dual_wheel_incremental_pi_drive #(
   parameter int SPEED_BITS     = dwpi_pkg::SPEED_BITS_DEF,
   parameter int GAIN_FRAC_BITS = dwpi_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   dwpi_req_if.sink     req_if,
   dwpi_rsp_if.source   rsp_if,
   dwpi_csr_if.sink     csr_if
);

   localparam int TW = dwpi_pkg::target_width(SPEED_BITS);
   localparam int DW = dwpi_pkg::drive_width(SPEED_BITS);

   logic [dwpi_pkg::GAIN_W-1:0]   gain_prop_ff;
   logic [dwpi_pkg::GAIN_W-1:0]   gain_diff_ff;
   logic [dwpi_pkg::LIMIT_W-1:0]  drive_limit_ff;
   logic [dwpi_pkg::OFFSET_W-1:0] sharp_offset_ff;
   logic [dwpi_pkg::SCALE_W-1:0]  direct_scale_ff;
   dwpi_pkg::lane_cfg_type        lane_cfg;

   logic v1_ff;
   logic v2_ff;
   logic v3_ff;
   logic en1;
   logic en2;
   logic en3;
   dwpi_pkg::lane_ctl_type lane_ctl;

   logic signed [TW-1:0] spd;
   logic signed [TW-1:0] spd_half;
   logic signed [TW-1:0] spd_sharp;
   logic signed [TW-1:0] target_left;
   logic signed [TW-1:0] target_right;
   dwpi_pkg::lane_mode_type mode_left;
   dwpi_pkg::lane_mode_type mode_right;
   logic signed [DW-1:0] drive_left;
   logic signed [DW-1:0] drive_right;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff    <= dwpi_pkg::GAIN_PROP_RST;
         gain_diff_ff    <= dwpi_pkg::GAIN_DIFF_RST;
         drive_limit_ff  <= dwpi_pkg::DRIVE_LIMIT_RST;
         sharp_offset_ff <= dwpi_pkg::SHARP_OFFSET_RST;
         direct_scale_ff <= dwpi_pkg::DIRECT_SCALE_RST;
      end else if (csr_if.valid) begin
         case (dwpi_pkg::reg_index_type'(csr_if.index))
            dwpi_pkg::REG_GAIN_PROP: begin
               gain_prop_ff <= csr_if.data[dwpi_pkg::GAIN_W-1:0];
            end
            dwpi_pkg::REG_GAIN_DIFF: begin
               gain_diff_ff <= csr_if.data[dwpi_pkg::GAIN_W-1:0];
            end
            dwpi_pkg::REG_DRIVE_LIMIT: begin
               drive_limit_ff <= csr_if.data[dwpi_pkg::LIMIT_W-1:0];
            end
            dwpi_pkg::REG_SHARP_OFFSET: begin
               sharp_offset_ff <= csr_if.data[dwpi_pkg::OFFSET_W-1:0];
            end
            dwpi_pkg::REG_DIRECT_SCALE: begin
               direct_scale_ff <= csr_if.data[dwpi_pkg::SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      lane_cfg.gain_prop    = gain_prop_ff;
      lane_cfg.gain_diff    = gain_diff_ff;
      lane_cfg.drive_limit  = drive_limit_ff;
      lane_cfg.direct_scale = direct_scale_ff;
   end

   always_comb begin
      en3            = !v3_ff || rsp_if.ready;
      en2            = !v2_ff || en3;
      en1            = !v1_ff || en2;
      req_if.ready   = en1;
      lane_ctl.load1 = req_if.valid && en1;
      lane_ctl.load2 = v1_ff && en2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_if.valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // Halving rounds toward zero, so negative odd speeds get one added first.
   always_comb begin
      spd       = TW'(req_if.target_speed);
      spd_half  = (spd + $signed({{(TW-1){1'b0}}, spd[TW-1]})) >>> 1;
      spd_sharp = spd + $signed({{(TW-dwpi_pkg::OFFSET_W){1'b0}}, sharp_offset_ff});
      target_left  = spd;
      target_right = spd;
      mode_left    = dwpi_pkg::LANE_PI;
      mode_right   = dwpi_pkg::LANE_PI;
      case (dwpi_pkg::op_type'(req_if.op))
         dwpi_pkg::OP_STOP: begin
            mode_left  = dwpi_pkg::LANE_ZERO;
            mode_right = dwpi_pkg::LANE_ZERO;
         end
         dwpi_pkg::OP_LEFT:        target_left  = spd_half;
         dwpi_pkg::OP_RIGHT:       target_right = spd_half;
         dwpi_pkg::OP_SHARP_LEFT:  target_right = spd_sharp;
         dwpi_pkg::OP_SHARP_RIGHT: target_left  = spd_sharp;
         dwpi_pkg::OP_FIND: begin
            mode_left  = dwpi_pkg::LANE_DIRECT;
            mode_right = dwpi_pkg::LANE_ZERO;
         end
         dwpi_pkg::OP_ADJUST: begin
            mode_left  = dwpi_pkg::LANE_DIRECT;
            mode_right = dwpi_pkg::LANE_DIRECT;
         end
         default: begin
         end
      endcase
   end

   dwpi_lane #(
      .SPEED_BITS     (SPEED_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_lane_left (
      .clock        (clock),
      .reset        (reset),
      .ctl          (lane_ctl),
      .cfg          (lane_cfg),
      .mode         (mode_left),
      .target       (target_left),
      .measured     (req_if.measured_left),
      .direct_speed (req_if.target_speed),
      .drive        (drive_left)
   );

   dwpi_lane #(
      .SPEED_BITS     (SPEED_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_lane_right (
      .clock        (clock),
      .reset        (reset),
      .ctl          (lane_ctl),
      .cfg          (lane_cfg),
      .mode         (mode_right),
      .target       (target_right),
      .measured     (req_if.measured_right),
      .direct_speed (req_if.target_speed_right),
      .drive        (drive_right)
   );

   dwpi_merge #(
      .SPEED_BITS (SPEED_BITS)
   ) u_merge (
      .clock         (clock),
      .load          (v2_ff && en3),
      .drive_left    (drive_left),
      .drive_right   (drive_right),
      .left_forward  (rsp_if.left_forward),
      .left_duty     (rsp_if.left_duty),
      .right_forward (rsp_if.right_forward),
      .right_duty    (rsp_if.right_duty)
   );

   assign rsp_if.valid = v3_ff;

   `DWPI_ASSERT_IMPLY(a_stall_only_when_full, clock, reset, !req_if.ready, v1_ff && v2_ff && v3_ff, "request stalled while the pipeline has room")
   `DWPI_ASSERT_IMPLY(a_full_blocked_stalls, clock, reset, v1_ff && v2_ff && v3_ff && !rsp_if.ready, !req_if.ready, "request taken while the full pipeline is blocked")
   `DWPI_ASSERT_IMPLY(a_rsp_from_stage_two, clock, reset, $rose(v3_ff), $past(v2_ff), "response appeared without a request in the lane pipeline")
   `DWPI_ASSERT_NEXT(a_accept_fills_stage_one, clock, reset, req_if.valid && req_if.ready, v1_ff, "accepted request did not enter the lanes")

endmodule

// File: bench/tb_dual_wheel_incremental_pi_drive.sv
// Self-checking testbench of the dual-wheel incremental PI drive, with its own drive predictor.
`timescale 1ns / 100ps

module tb_dual_wheel_incremental_pi_drive;
   import dwpi_pkg::*;

   localparam int SPEED_W = SPEED_BITS_DEF;
   localparam int FRAC_W = GAIN_FRAC_BITS_DEF;
   localparam int ERR_W = SPEED_W + 2;
   localparam longint Q_ONE = longint'(1) << FRAC_W;
   localparam int CLOCK_HALF = 2;
   localparam int TIMEOUT_NS = 2_000_000;
   localparam int NUM_DIRECTED = 23;
   localparam int NUM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int BURST_ITEMS = 30;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam int DRAIN_CYCLES = 20;
   localparam int LEFT_WHEEL = 0;
   localparam int RIGHT_WHEEL = 1;

   typedef logic signed [SPEED_W-1:0] speed_t;

   localparam speed_t S_MAX = speed_t'((1 << (SPEED_W - 1)) - 1);
   localparam speed_t S_MIN = speed_t'(-(1 << (SPEED_W - 1)));

   typedef struct packed {
      op_type op;
      speed_t speed;
      speed_t speed_right;
      speed_t meas_left;
      speed_t meas_right;
   } drive_cmd_t;

   typedef struct packed {
      logic              left_forward;
      logic [DUTY_W-1:0] left_duty;
      logic              right_forward;
      logic [DUTY_W-1:0] right_duty;
   } wheel_drive_t;

   typedef struct packed {
      drive_cmd_t   cmd;
      logic         known;
      wheel_drive_t want;
   } directed_row_t;

   typedef struct packed {
      logic                drawn;
      logic [GAIN_W-1:0]   gain_prop;
      logic [GAIN_W-1:0]   gain_diff;
      logic [LIMIT_W-1:0]  drive_limit;
      logic [OFFSET_W-1:0] sharp_offset;
      logic [SCALE_W-1:0]  direct_scale;
   } settings_t;

   logic clock;
   logic reset;

   dwpi_req_if #(.SPEED_BITS(SPEED_W)) request_ch ();
   dwpi_rsp_if response_ch ();
   dwpi_csr_if csr_ch ();

   dual_wheel_incremental_pi_drive #(
      .SPEED_BITS     (SPEED_W),
      .GAIN_FRAC_BITS (FRAC_W)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (request_ch),
      .rsp_if (response_ch),
      .csr_if (csr_ch)
   );

   logic [GAIN_W-1:0]         cfg_gain_prop = GAIN_PROP_RST;
   logic [GAIN_W-1:0]         cfg_gain_diff = GAIN_DIFF_RST;
   logic [LIMIT_W-1:0]        cfg_drive_limit = DRIVE_LIMIT_RST;
   logic [OFFSET_W-1:0]       cfg_sharp_offset = SHARP_OFFSET_RST;
   logic [SCALE_W-1:0]        cfg_direct_scale = DIRECT_SCALE_RST;
   logic signed [ACC_W-1:0]   wheel_accum [2] = '{'0, '0};
   logic signed [ERR_W-1:0]   wheel_last_err [2] = '{'0, '0};

   wheel_drive_t pending_drives [$];
   int  mismatches = 0;
   int  requests_sent = 0;
   int  responses_checked = 0;
   int  input_stall_cycles = 0;
   int  settings_used = 1;
   bit  long_hold_pending = 1'b0;

   directed_row_t directed_rows [NUM_DIRECTED] = '{
      '{'{OP_STOP, S_MAX, S_MIN, S_MAX, S_MIN}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{OP_FIND, S_MAX, S_MIN, S_MIN, S_MAX}, 1'b1, '{1'b1, 16'd25500, 1'b0, 16'd0}},
      '{'{OP_FIND, S_MIN, S_MAX, 9'sd0, 9'sd0}, 1'b1, '{1'b0, 16'd25600, 1'b0, 16'd0}},
      '{'{OP_FIND, 9'sd0, S_MAX, 9'sd0, 9'sd0}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{OP_ADJUST, S_MAX, S_MIN, 9'sd0, 9'sd0}, 1'b1, '{1'b1, 16'd25500, 1'b0, 16'd25600}},
      '{'{OP_ADJUST, S_MIN, S_MAX, S_MAX, S_MIN}, 1'b1, '{1'b0, 16'd25600, 1'b1, 16'd25500}},
      '{'{OP_ADJUST, 9'sd1, -9'sd1, 9'sd0, 9'sd0}, 1'b1, '{1'b1, 16'd100, 1'b0, 16'd100}},
      '{'{OP_FORWARD, 9'sd0, S_MAX, 9'sd0, 9'sd0}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{OP_FORWARD, S_MAX, S_MIN, S_MIN, S_MAX}, 1'b0, '0},
      '{'{OP_FORWARD, S_MAX, 9'sd0, S_MIN, S_MAX}, 1'b0, '0},
      '{'{OP_LEFT, S_MAX, 9'sd0, 9'sd0, 9'sd0}, 1'b0, '0},
      '{'{OP_LEFT, -9'sd255, 9'sd0, 9'sd0, 9'sd0}, 1'b0, '0},
      '{'{OP_LEFT, -9'sd1, 9'sd0, 9'sd0, 9'sd0}, 1'b0, '0},
      '{'{OP_RIGHT, S_MAX, 9'sd37, 9'sd10, -9'sd10}, 1'b0, '0},
      '{'{OP_RIGHT, -9'sd255, 9'sd0, 9'sd0, 9'sd0}, 1'b0, '0},
      '{'{OP_SHARP_LEFT, S_MAX, 9'sd0, S_MIN, S_MIN}, 1'b0, '0},
      '{'{OP_SHARP_LEFT, S_MIN, 9'sd0, S_MAX, S_MAX}, 1'b0, '0},
      '{'{OP_SHARP_RIGHT, S_MAX, S_MIN, S_MIN, 9'sd0}, 1'b0, '0},
      '{'{OP_SHARP_RIGHT, S_MIN, 9'sd0, 9'sd0, 9'sd0}, 1'b0, '0},
      '{'{OP_FORWARD, S_MIN, 9'sd0, S_MAX, S_MAX}, 1'b0, '0},
      '{'{OP_STOP, 9'sd0, 9'sd0, 9'sd0, 9'sd0}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{OP_FIND, 9'sd1, S_MIN, S_MAX, S_MAX}, 1'b1, '{1'b1, 16'd100, 1'b0, 16'd0}},
      '{'{OP_FORWARD, 9'sd20, 9'sd0, 9'sd20, 9'sd20}, 1'b0, '0}
   };

   settings_t phase_settings [NUM_PHASES] = '{
      '{1'b0, GAIN_PROP_RST, GAIN_DIFF_RST, DRIVE_LIMIT_RST, SHARP_OFFSET_RST, DIRECT_SCALE_RST},
      '{1'b0, 16'hFFFF, 16'hFFFF, 15'h7FFF, 6'h3F, 8'hFF},
      '{1'b0, 16'd0, 16'd0, 15'd0, 6'd0, 8'd0},
      '{1'b0, 16'd4096, 16'd0, 15'd1000, 6'd1, 8'd1},
      '{1'b0, 16'd0, 16'd4096, 15'd32767, 6'd32, 8'd128},
      '{1'b1, 16'd0, 16'd0, 15'd0, 6'd0, 8'd0},
      '{1'b1, 16'd0, 16'd0, 15'd0, 6'd0, 8'd0},
      '{1'b0, 16'd20000, 16'd3000, 15'd1, 6'd63, 8'd0}
   };

   initial clock = 1'b0;
   always #(CLOCK_HALF) clock = ~clock;

   task automatic report_mismatch(input string field, input longint got, input longint want);
      mismatches++;
      $display("ERROR at %0t: response %0d, %s is %0d, expected %0d",
               $time, responses_checked, field, got, want);
   endtask

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] reg_idx,
                                          input logic [CSR_DATA_W-1:0] value);
      case (reg_idx)
         REG_GAIN_PROP:    cfg_gain_prop = value;
         REG_GAIN_DIFF:    cfg_gain_diff = value;
         REG_DRIVE_LIMIT:  cfg_drive_limit = value[LIMIT_W-1:0];
         REG_SHARP_OFFSET: cfg_sharp_offset = value[OFFSET_W-1:0];
         REG_DIRECT_SCALE: cfg_direct_scale = value[SCALE_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic longint pi_wheel_update(input int wheel, input longint target,
                                              input longint measured);
      longint err;
      longint sum;
      longint next_acc;
      longint bound;
      err = target - measured;
      sum = longint'(wheel_accum[wheel]) * Q_ONE
          + longint'(cfg_gain_diff) * (err - longint'(wheel_last_err[wheel]))
          + longint'(cfg_gain_prop) * err;
      // Signed division truncates toward zero, applied to the whole new sum.
      next_acc = sum / Q_ONE;
      bound = longint'(cfg_drive_limit);
      if (next_acc > bound) begin
         next_acc = bound;
      end else if (next_acc < -bound) begin
         next_acc = -bound;
      end
      wheel_accum[wheel] = ACC_W'(next_acc);
      wheel_last_err[wheel] = ERR_W'(err);
      return next_acc;
   endfunction

   function automatic logic [DUTY_W:0] wheel_output(input longint drive);
      return {drive > 0, DUTY_W'(drive < 0 ? -drive : drive)};
   endfunction

   function automatic wheel_drive_t predict_drive(input drive_cmd_t c);
      longint spd;
      longint tl;
      longint tr;
      longint dl;
      longint dr;
      wheel_drive_t w;
      spd = longint'(signed'(c.speed));
      tl = spd;
      tr = spd;
      dl = 0;
      dr = 0;
      case (c.op)
         OP_LEFT:        tl = spd / 2;
         OP_RIGHT:       tr = spd / 2;
         OP_SHARP_LEFT:  tr = spd + longint'(cfg_sharp_offset);
         OP_SHARP_RIGHT: tl = spd + longint'(cfg_sharp_offset);
         default: ;
      endcase
      case (c.op)
         OP_FORWARD, OP_LEFT, OP_RIGHT, OP_SHARP_LEFT, OP_SHARP_RIGHT: begin
            dl = pi_wheel_update(LEFT_WHEEL, tl, longint'(signed'(c.meas_left)));
            dr = pi_wheel_update(RIGHT_WHEEL, tr, longint'(signed'(c.meas_right)));
         end
         OP_FIND: begin
            dl = spd * longint'(cfg_direct_scale);
         end
         OP_ADJUST: begin
            dl = spd * longint'(cfg_direct_scale);
            dr = longint'(signed'(c.speed_right)) * longint'(cfg_direct_scale);
         end
         default: ;
      endcase
      {w.left_forward, w.left_duty} = wheel_output(dl);
      {w.right_forward, w.right_duty} = wheel_output(dr);
      return w;
   endfunction

   function automatic speed_t pick_speed();
      case ($urandom_range(0, 9))
         0: return S_MAX;
         1: return S_MIN;
         2: return speed_t'(0);
         3: return speed_t'(-1);
         4, 5, 6: return speed_t'(int'($urandom_range(0, 80)) - 40);
         default: return speed_t'($urandom);
      endcase
   endfunction

   function automatic speed_t near_speed(input speed_t centre);
      int v;
      v = int'(centre) + int'($urandom_range(0, 16)) - 8;
      if (v > int'(S_MAX)) begin
         v = int'(S_MAX);
      end
      if (v < int'(S_MIN)) begin
         v = int'(S_MIN);
      end
      return speed_t'(v);
   endfunction

   function automatic drive_cmd_t random_command();
      drive_cmd_t c;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         c.op = op_type'($urandom_range(OP_FORWARD, OP_SHARP_RIGHT));
      end else if (pick < 88) begin
         c.op = op_type'($urandom_range(OP_FIND, OP_ADJUST));
      end else begin
         c.op = op_type'($urandom_range(OP_STOP, OP_ADJUST));
      end
      c.speed = pick_speed();
      c.speed_right = pick_speed();
      c.meas_left = ($urandom_range(0, 1) != 0) ? near_speed(c.speed) : pick_speed();
      c.meas_right = ($urandom_range(0, 1) != 0) ? near_speed(c.speed) : pick_speed();
      return c;
   endfunction

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic send_command(input drive_cmd_t c, input logic known, input wheel_drive_t want);
      wheel_drive_t predicted;
      request_ch.valid <= 1'b1;
      request_ch.op <= c.op;
      request_ch.target_speed <= c.speed;
      request_ch.target_speed_right <= c.speed_right;
      request_ch.measured_left <= c.meas_left;
      request_ch.measured_right <= c.meas_right;
      @(posedge clock);
      while (!request_ch.ready) begin
         @(posedge clock);
      end
      predicted = predict_drive(c);
      pending_drives.push_back(known ? want : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic pause_sender(input int gap);
      if (gap > 0) begin
         request_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      while (pending_drives.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] reg_idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= reg_idx;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) begin
         @(posedge clock);
      end
      apply_register(reg_idx, value);
      @(negedge clock);
   endtask

   task automatic program_settings(input settings_t s);
      write_register(REG_GAIN_PROP, s.gain_prop);
      write_register(REG_GAIN_DIFF, s.gain_diff);
      write_register(REG_DRIVE_LIMIT, CSR_DATA_W'(s.drive_limit));
      write_register(REG_SHARP_OFFSET, CSR_DATA_W'(s.sharp_offset));
      write_register(REG_DIRECT_SCALE, CSR_DATA_W'(s.direct_scale));
      // Writes to indexes past the last register must leave every setting alone.
      for (int i = int'(REG_DIRECT_SCALE) + 1; i < (1 << CSR_IDX_W); i++) begin
         write_register(CSR_IDX_W'(i), '1);
      end
      csr_ch.valid <= 1'b0;
   endtask

   initial begin : stimulus
      settings_t s;
      reset = 1'b1;
      request_ch.valid = 1'b0;
      request_ch.op = OP_STOP;
      request_ch.target_speed = '0;
      request_ch.target_speed_right = '0;
      request_ch.measured_left = '0;
      request_ch.measured_right = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_GAIN_PROP;
      csr_ch.data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_DIRECTED; r++) begin
         send_command(directed_rows[r].cmd, directed_rows[r].known, directed_rows[r].want);
         pause_sender(pick_gap());
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         s = phase_settings[phase];
         if (phase != 0) begin
            request_ch.valid <= 1'b0;
            wait_drained();
            if (s.drawn) begin
               s.gain_prop = GAIN_W'($urandom_range(0, 16384));
               s.gain_diff = GAIN_W'($urandom_range(0, 16384));
               s.drive_limit = LIMIT_W'($urandom_range(1, 32767));
               s.sharp_offset = OFFSET_W'($urandom_range(0, 63));
               s.direct_scale = SCALE_W'($urandom_range(0, 255));
            end
            program_settings(s);
            settings_used++;
         end
         // The response side holds off for a long stretch while this burst keeps coming.
         if (phase == 1) begin
            long_hold_pending = 1'b1;
         end
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            send_command(random_command(), 1'b0, '0);
            if (k >= BURST_ITEMS) begin
               pause_sender(pick_gap());
            end
         end
      end

      request_ch.valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Summary: %0d requests over all eight modes (%0d directed) under %0d settings,",
               requests_sent, NUM_DIRECTED, settings_used);
      $display("including all-zero and all-maximum gains; %0d responses checked, %0d stall cycles.",
               responses_checked, input_stall_cycles);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : response_sink
      int hold_left;
      int run_left;
      int pick;
      hold_left = 0;
      run_left = 0;
      response_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset) begin
            if (long_hold_pending) begin
               long_hold_pending = 1'b0;
               hold_left = LONG_HOLD_CYCLES;
               run_left = 1;
            end
            if (hold_left == 0 && run_left == 0) begin
               pick = $urandom_range(0, 99);
               if (pick < 60) begin
                  hold_left = 0;
               end else if (pick < 90) begin
                  hold_left = $urandom_range(1, 3);
               end else begin
                  hold_left = $urandom_range(10, 40);
               end
               if ($urandom_range(0, 99) < 80) begin
                  run_left = $urandom_range(1, 6);
               end else begin
                  run_left = $urandom_range(20, 80);
               end
            end
            if (hold_left > 0) begin
               response_ch.ready <= 1'b0;
               hold_left--;
            end else begin
               response_ch.ready <= 1'b1;
               run_left--;
            end
         end
      end
   end

   always @(posedge clock) begin : check_responses
      wheel_drive_t want;
      if (!reset && response_ch.valid && response_ch.ready) begin
         if (pending_drives.size() == 0) begin
            report_mismatch("unexpected response, left_duty", response_ch.left_duty, 0);
         end else begin
            want = pending_drives.pop_front();
            if (response_ch.left_forward !== want.left_forward) begin
               report_mismatch("left_forward", response_ch.left_forward, want.left_forward);
            end
            if (response_ch.left_duty !== want.left_duty) begin
               report_mismatch("left_duty", response_ch.left_duty, want.left_duty);
            end
            if (response_ch.right_forward !== want.right_forward) begin
               report_mismatch("right_forward", response_ch.right_forward, want.right_forward);
            end
            if (response_ch.right_duty !== want.right_duty) begin
               report_mismatch("right_duty", response_ch.right_duty, want.right_duty);
            end
         end
         responses_checked++;
      end
   end

   always @(posedge clock) begin
      if (!reset && request_ch.valid && !request_ch.ready) begin
         input_stall_cycles++;
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: dual_wheel_incremental_pi_drive.f
+incdir+sv
sv/dwpi_pkg.sv
sv/dwpi_ifs.sv
sv/dwpi_lane.sv
sv/dwpi_merge.sv
sv/dual_wheel_incremental_pi_drive.sv
bench/tb_dual_wheel_incremental_pi_drive.sv
